>>> sv/cbg_pkg.sv
// Shared types and constants for the CPU bus glue block.
// No dependencies; imported by cbg_ram and cpu_bus_glue_oam_dma_joypad.
`default_nettype none

package cbg_pkg;

    // Command codes of an input beat
    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_BUTTONS = 2'd3;

    // Route codes of a result beat
    localparam logic [1:0] ROUTE_NONE  = 2'd0;
    localparam logic [1:0] ROUTE_PPU   = 2'd1;
    localparam logic [1:0] ROUTE_AUDIO = 2'd2;
    localparam logic [1:0] ROUTE_CART  = 2'd3;

    // Address map
    localparam logic [15:0] ADDR_RAM_TOP    = 16'h1FFF;
    localparam logic [15:0] ADDR_PPU_TOP    = 16'h3FFF;
    localparam logic [15:0] ADDR_APU_FIRST  = 16'h4000;
    localparam logic [15:0] ADDR_APU_LAST   = 16'h4013;
    localparam logic [15:0] ADDR_OAM_DMA    = 16'h4014;
    localparam logic [15:0] ADDR_APU_STATUS = 16'h4015;
    localparam logic [15:0] ADDR_JOY1       = 16'h4016;
    localparam logic [15:0] ADDR_JOY2       = 16'h4017;
    localparam logic [15:0] PPU_REG_MASK    = 16'h0007;

    // Upper bits returned by a joypad port read
    localparam logic [7:0]  JOY_OPEN_BUS    = 8'h40;

    // Tick phase counter runs 0..5
    localparam logic [2:0]  PHASE_LAST      = 3'd5;
    localparam logic [2:0]  PHASE_CPU_A     = 3'd0;
    localparam logic [2:0]  PHASE_CPU_B     = 3'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  external_data;
        logic        cart_claims;
        logic        instruction_done;
        logic [7:0]  buttons;
    } t_in;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  route;
        logic [15:0] route_address;
        logic        route_write;
        logic [7:0]  route_data;
        logic        cpu_step;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_data;
        logic        dma_busy;
    } t_out;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

`default_nettype wire

>>> sv/cbg_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing but imports cbg_pkg for house consistency.
`default_nettype none

module cbg_ram
    import cbg_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sv/cpu_bus_glue_oam_dma_joypad.sv
// CPU bus glue: address decode, work RAM, joypad shift ports, OAM DMA sequencing.
// Depends on cbg_pkg (types, codes, address map) and cbg_ram (work RAM).
//
//   port group    | direction | handshake                  | beat
//   i_in          | in        | i_in_valid / o_in_ready    | one bus event (t_in)
//   o_out         | out       | o_out_valid / i_out_ready  | one result (t_out)
//   i_cfg_*       | in        | i_cfg_we, no wait          | audio_muted bit
//
// Each beat first reads the work RAM (registered read), then modifies, writes
// back and loads the result register; the RAM port sets this.
// The next beat is taken while a finished result still waits in o_out.
// After reset a clearing pass writes zero to every RAM entry while o_in_ready
// stays low; configuration writes are taken as ever.
// Reset is synchronous, active low.
`default_nettype none

module cpu_bus_glue_oam_dma_joypad
    import cbg_pkg::*;
#(
    parameter int RAM_BYTES = 2048
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_data,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);

    localparam int AW        = $clog2(RAM_BYTES);
    localparam int SPAN      = int'(ADDR_RAM_TOP) + 1;
    localparam int Q_BITS    = $clog2((SPAN + RAM_BYTES - 1) / RAM_BYTES);
    localparam logic [AW-1:0] LAST_IDX = AW'(RAM_BYTES - 1);

    // Control and state registers
    t_state       r_state, n_state;
    logic [AW-1:0] r_clr_idx;
    logic         r_out_valid;
    logic         r_muted;
    logic [7:0]   r_shift   [2];
    logic [7:0]   n_shift   [2];
    logic [7:0]   r_pending [2];
    logic [7:0]   n_pending [2];
    logic         r_strobe, n_strobe;
    logic         r_next_player, n_next_player;
    logic [2:0]   r_phase, n_phase;
    logic         r_armed, n_armed;
    logic         r_running, n_running;
    logic [7:0]   r_page, n_page;
    logic [7:0]   r_offset, n_offset;
    logic [7:0]   r_holding, n_holding;

    // Payload registers
    t_in          r_item;
    t_out         r_out;
    t_out         res;

    // RAM port and control
    logic [15:0]   bus_a;
    logic [13:0]   rem;
    logic [AW-1:0] slot;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_q;
    logic          dp_ram_we;
    logic          out_free;
    logic          exec_fire;

    cbg_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (slot),
        .o_rdata (ram_q)
    );

    // Pick the bus address: a tick targets the DMA source
    always_comb begin
        if (r_state == ST_EXEC) begin
            bus_a = (r_item.command == CMD_TICK) ? {r_page, r_offset} : r_item.address;
        end else begin
            bus_a = (i_in.command == CMD_TICK) ? {r_page, r_offset} : i_in.address;
        end
    end

    // Fold the mirrored address onto the RAM depth, one quotient bit a step
    always_comb begin
        rem = {1'b0, bus_a[12:0]};
        for (int k = Q_BITS - 1; k >= 0; k--) begin
            if (rem >= (14'(RAM_BYTES) << k)) begin
                rem = rem - (14'(RAM_BYTES) << k);
            end
        end
        slot = rem[AW-1:0];
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // State outputs: handshake and RAM write port
    always_comb begin
        o_in_ready = 1'b0;
        exec_fire  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = slot;
        ram_wdata  = r_item.write_data;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_EXEC: begin
                exec_fire = out_free;
                ram_we    = out_free && dp_ram_we;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Execute one bus event against the current state
    always_comb begin
        logic       do_read;
        logic       dma_rd;
        logic       run;
        logic [7:0] rd_byte;
        logic       port;

        do_read       = 1'b0;
        dma_rd        = 1'b0;
        run           = 1'b0;
        rd_byte       = '0;
        port          = bus_a[0];
        dp_ram_we     = 1'b0;
        res           = '0;
        n_shift       = r_shift;
        n_pending     = r_pending;
        n_strobe      = r_strobe;
        n_next_player = r_next_player;
        n_phase       = r_phase;
        n_armed       = r_armed;
        n_running     = r_running;
        n_page        = r_page;
        n_offset      = r_offset;
        n_holding     = r_holding;

        unique case (r_item.command)
            CMD_READ: begin
                do_read = 1'b1;
            end
            CMD_WRITE: begin
                if (r_item.cart_claims) begin
                    res.route         = ROUTE_CART;
                    res.route_address = bus_a;
                    res.route_write   = 1'b1;
                    res.route_data    = r_item.write_data;
                end else if (bus_a <= ADDR_RAM_TOP) begin
                    dp_ram_we = 1'b1;
                end else if (bus_a <= ADDR_PPU_TOP) begin
                    res.route         = ROUTE_PPU;
                    res.route_address = bus_a & PPU_REG_MASK;
                    res.route_write   = 1'b1;
                    res.route_data    = r_item.write_data;
                end else if ((bus_a >= ADDR_APU_FIRST && bus_a <= ADDR_APU_LAST)
                             || bus_a == ADDR_APU_STATUS) begin
                    if (!r_muted) begin
                        res.route         = ROUTE_AUDIO;
                        res.route_address = bus_a;
                        res.route_write   = 1'b1;
                        res.route_data    = r_item.write_data;
                    end
                end else if (bus_a == ADDR_OAM_DMA) begin
                    n_page   = r_item.write_data;
                    n_offset = '0;
                    n_armed  = 1'b1;
                end else if (bus_a == ADDR_JOY1) begin
                    // strobe high latches both pads
                    n_strobe = r_item.write_data[0];
                    if (r_item.write_data[0]) begin
                        n_shift[0] = r_pending[0];
                        n_shift[1] = r_pending[1];
                    end
                end
            end
            CMD_TICK: begin
                if (r_phase == PHASE_CPU_A || r_phase == PHASE_CPU_B) begin
                    if (r_armed && r_item.instruction_done) begin
                        // DMA starts on a read phase, then alternates read and write
                        run       = r_running || r_phase[0];
                        n_running = run;
                        if (run) begin
                            if (r_phase[0]) begin
                                dma_rd = 1'b1;
                            end else begin
                                res.oam_write = 1'b1;
                                res.oam_index = r_offset;
                                res.oam_data  = r_holding;
                                n_offset      = r_offset + 8'd1;
                                if (r_offset == 8'hFF) begin
                                    n_armed   = 1'b0;
                                    n_running = 1'b0;
                                end
                            end
                        end
                    end else begin
                        res.cpu_step = 1'b1;
                    end
                end
                n_phase = (r_phase == PHASE_LAST) ? 3'd0 : r_phase + 3'd1;
            end
            CMD_BUTTONS: begin
                n_pending[r_next_player] = r_item.buttons;
                n_next_player            = !r_next_player;
            end
            default: begin
                do_read = 1'b0;
            end
        endcase

        // Read decode, shared by CPU reads and DMA source reads
        if (do_read || dma_rd) begin
            if (bus_a <= ADDR_RAM_TOP) begin
                rd_byte = ram_q;
            end else if (bus_a <= ADDR_PPU_TOP) begin
                res.route         = ROUTE_PPU;
                res.route_address = bus_a & PPU_REG_MASK;
                rd_byte           = r_item.external_data;
            end else if (bus_a == ADDR_APU_STATUS) begin
                if (!r_muted) begin
                    res.route         = ROUTE_AUDIO;
                    res.route_address = bus_a;
                    rd_byte           = r_item.external_data;
                end
            end else if (bus_a == ADDR_JOY1 || bus_a == ADDR_JOY2) begin
                rd_byte = JOY_OPEN_BUS | {7'd0, r_shift[port][0]};
                if (!r_strobe) begin
                    n_shift[port] = {1'b0, r_shift[port][7:1]};
                end
            end else if (r_item.cart_claims) begin
                res.route         = ROUTE_CART;
                res.route_address = bus_a;
                rd_byte           = r_item.external_data;
            end
        end

        if (do_read) begin
            res.read_data = rd_byte;
        end
        if (dma_rd) begin
            n_holding = rd_byte;
        end
        res.dma_busy = n_armed || n_running;
    end

    // Control state and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_idx     <= '0;
            r_out_valid   <= 1'b0;
            r_muted       <= 1'b0;
            r_shift[0]    <= '0;
            r_shift[1]    <= '0;
            r_pending[0]  <= '0;
            r_pending[1]  <= '0;
            r_strobe      <= 1'b0;
            r_next_player <= 1'b0;
            r_phase       <= '0;
            r_armed       <= 1'b0;
            r_running     <= 1'b0;
            r_page        <= '0;
            r_offset      <= '0;
            r_holding     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_muted <= i_cfg_data;
            end
            // advance the clearing sweep
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            // hold the result until the sink takes it
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // commit the event's state changes
            if (exec_fire) begin
                r_shift       <= n_shift;
                r_pending     <= n_pending;
                r_strobe      <= n_strobe;
                r_next_player <= n_next_player;
                r_phase       <= n_phase;
                r_armed       <= n_armed;
                r_running     <= n_running;
                r_page        <= n_page;
                r_offset      <= n_offset;
                r_holding     <= n_holding;
            end
        end
    end

    // Capture the input beat and the result beat
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in;
        end
        if (exec_fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for cpu_bus_glue_oam_dma_joypad: directed and random bus beats checked
// field by field against an in-bench model of decode, joypad ports and OAM DMA.
// Depends on cbg_pkg and the RTL of the block; reads no files.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbg_pkg::*;

    localparam int RAM_BYTES    = 2048;
    localparam int AW           = $clog2(RAM_BYTES);
    localparam int HOLD_CYCLES  = 80;
    localparam int REPORT_LIMIT = 10;

    // Scoreboard: models the bus glue state and keeps the outstanding results
    class bus_glue_board;
        bit         muted;
        logic [7:0] ram [RAM_BYTES];
        logic [7:0] pad_shift [2];
        logic [7:0] pad_pending [2];
        bit         strobe;
        bit         player;
        logic [2:0] phase;
        bit         dma_armed;
        bit         dma_running;
        logic [7:0] src_page;
        logic [7:0] dma_offset;
        logic [7:0] dma_byte;
        t_out       pending_results [$];
        int         mismatches;

        function new();
            foreach (ram[i]) ram[i] = 8'h00;
            pad_shift   = '{8'h00, 8'h00};
            pad_pending = '{8'h00, 8'h00};
            phase       = 3'd0;
            src_page    = 8'h00;
            dma_offset  = 8'h00;
            dma_byte    = 8'h00;
        endfunction

        // Fold a mirrored work RAM address onto the RAM depth
        function logic [AW-1:0] ram_slot(logic [15:0] a);
            return AW'(int'(a & ADDR_RAM_TOP) % RAM_BYTES);
        endfunction

        // Decode a read, fill the route fields and return the byte seen
        function logic [7:0] bus_read(logic [15:0] a, logic [7:0] ext, bit cart,
                                      inout t_out r);
            logic [7:0] d;
            bit         p;
            d = 8'h00;
            if (a <= ADDR_RAM_TOP) begin
                d = ram[ram_slot(a)];
            end else if (a <= ADDR_PPU_TOP) begin
                r.route         = ROUTE_PPU;
                r.route_address = a & PPU_REG_MASK;
                d               = ext;
            end else if (a == ADDR_APU_STATUS) begin
                if (!muted) begin
                    r.route         = ROUTE_AUDIO;
                    r.route_address = a;
                    d               = ext;
                end
            end else if (a == ADDR_JOY1 || a == ADDR_JOY2) begin
                p = a[0];
                d = JOY_OPEN_BUS | {7'b0, pad_shift[p][0]};
                if (!strobe) pad_shift[p] = pad_shift[p] >> 1;
            end else if (cart) begin
                r.route         = ROUTE_CART;
                r.route_address = a;
                d               = ext;
            end
            return d;
        endfunction

        // Decode a write; the cartridge wins over every other decode
        function void bus_write(logic [15:0] a, logic [7:0] d, bit cart, inout t_out r);
            if (cart) begin
                r.route = ROUTE_CART; r.route_address = a;
                r.route_write = 1'b1; r.route_data = d;
            end else if (a <= ADDR_RAM_TOP) begin
                ram[ram_slot(a)] = d;
            end else if (a <= ADDR_PPU_TOP) begin
                r.route = ROUTE_PPU; r.route_address = a & PPU_REG_MASK;
                r.route_write = 1'b1; r.route_data = d;
            end else if ((a >= ADDR_APU_FIRST && a <= ADDR_APU_LAST)
                         || a == ADDR_APU_STATUS) begin
                if (!muted) begin
                    r.route = ROUTE_AUDIO; r.route_address = a;
                    r.route_write = 1'b1; r.route_data = d;
                end
            end else if (a == ADDR_OAM_DMA) begin
                src_page   = d;
                dma_offset = 8'h00;
                dma_armed  = 1'b1;
            end else if (a == ADDR_JOY1) begin
                if (d[0]) begin
                    strobe    = 1'b1;
                    pad_shift = pad_pending;
                end else begin
                    strobe = 1'b0;
                end
            end
        endfunction

        // Advance the phase; on the two slots give the CPU a step or run DMA
        function void run_tick(bit done, logic [7:0] ext, bit cart, inout t_out r);
            bit odd;
            odd = phase[0];
            if (phase == PHASE_CPU_A || phase == PHASE_CPU_B) begin
                if (dma_armed && done) begin
                    if (!dma_running && odd) dma_running = 1'b1;
                    if (dma_running) begin
                        if (odd) begin
                            dma_byte = bus_read({src_page, dma_offset}, ext, cart, r);
                        end else begin
                            r.oam_write = 1'b1;
                            r.oam_index = dma_offset;
                            r.oam_data  = dma_byte;
                            dma_offset  = dma_offset + 8'd1;
                            if (dma_offset == 8'h00) begin
                                dma_armed   = 1'b0;
                                dma_running = 1'b0;
                            end
                        end
                    end
                end else begin
                    r.cpu_step = 1'b1;
                end
            end
            phase = (phase == PHASE_LAST) ? 3'd0 : phase + 3'd1;
        endfunction

        // Predict the result of an accepted input beat and queue it
        function void note_beat(t_in b);
            t_out       r;
            logic [7:0] d;
            r = '0;
            case (b.command)
                CMD_READ: begin
                    d = bus_read(b.address, b.external_data, b.cart_claims, r);
                    r.read_data = d;
                end
                CMD_WRITE: bus_write(b.address, b.write_data, b.cart_claims, r);
                CMD_TICK:  run_tick(b.instruction_done, b.external_data, b.cart_claims, r);
                default: begin
                    pad_pending[player] = b.buttons;
                    player = ~player;
                end
            endcase
            r.dma_busy = dma_armed || dma_running;
            pending_results.push_back(r);
        endfunction

        function void report(string what, logic [15:0] want, logic [15:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what,
                         want, got);
        endfunction

        // Compare a result beat with the oldest prediction
        function void check_beat(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                report("result beat with nothing outstanding", 16'h0, 16'h0);
                return;
            end
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data)
                report("read_data", 16'(want.read_data), 16'(got.read_data));
            if (got.route !== want.route)
                report("route", 16'(want.route), 16'(got.route));
            if (got.route_address !== want.route_address)
                report("route_address", want.route_address, got.route_address);
            if (got.route_write !== want.route_write)
                report("route_write", 16'(want.route_write), 16'(got.route_write));
            if (got.route_data !== want.route_data)
                report("route_data", 16'(want.route_data), 16'(got.route_data));
            if (got.cpu_step !== want.cpu_step)
                report("cpu_step", 16'(want.cpu_step), 16'(got.cpu_step));
            if (got.oam_write !== want.oam_write)
                report("oam_write", 16'(want.oam_write), 16'(got.oam_write));
            if (got.oam_index !== want.oam_index)
                report("oam_index", 16'(want.oam_index), 16'(got.oam_index));
            if (got.oam_data !== want.oam_data)
                report("oam_data", 16'(want.oam_data), 16'(got.oam_data));
            if (got.dma_busy !== want.dma_busy)
                report("dma_busy", 16'(want.dma_busy), 16'(got.dma_busy));
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    bus_glue_board sb;
    bit            no_idle;
    bit            hold_req;
    int            beats_sent;

    cpu_bus_glue_oam_dma_joypad #(
        .RAM_BYTES (RAM_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drive result ready: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (no_idle) i_out_ready <= 1'b1;
            else         i_out_ready <= ($urandom_range(99) >= 16);
        end
    end

    // Check every result beat taken
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_beat(o_out);
        end
    end

    // Offer one input beat, idling at random first; entered and left at a falling edge
    task automatic send_beat(t_in b);
        while (!no_idle && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_beat(b);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic put(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wd, logic [7:0] ext,
                       bit cart, bit done, logic [7:0] btn);
        t_in b;
        b.command          = cmd;
        b.address          = addr;
        b.write_data       = wd;
        b.external_data    = ext;
        b.cart_claims      = cart;
        b.instruction_done = done;
        b.buttons          = btn;
        send_beat(b);
    endtask

    // Hold input valid low and wait until every prediction has been matched
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_muted(bit value);
        drain();
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.muted = value;
    endtask

    function automatic bit rare_cart();
        return $urandom_range(3) == 0;
    endfunction

    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)      a = 16'(($urandom_range(3) << 11) | $urandom_range(255));
        else if (r < 28) a = 16'($urandom_range(16'h1FFF));
        else if (r < 42) a = 16'($urandom_range(16'h2000, 16'h3FFF));
        else if (r < 52) a = 16'($urandom_range(ADDR_APU_FIRST, ADDR_APU_LAST));
        else if (r < 58) a = ADDR_APU_STATUS;
        else if (r < 70) a = 16'($urandom_range(ADDR_JOY1, ADDR_JOY2));
        else if (r < 74) a = ADDR_OAM_DMA;
        else if (r < 80) a = 16'($urandom_range(16'h4018, 16'h401F));
        else             a = 16'($urandom);
        return a;
    endfunction

    function automatic logic [7:0] pick_page();
        logic [7:0]  p;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)      p = 8'($urandom_range(8'h1F));
        else if (r < 60) p = 8'($urandom_range(8'h20, 8'h3F));
        else if (r < 75) p = 8'h40;
        else             p = 8'($urandom);
        return p;
    endfunction

    task automatic noise_beat();
        put(2'($urandom_range(3)), pick_address(), 8'($urandom), 8'($urandom),
            1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom));
    endtask

    task automatic tick_beat();
        put(CMD_TICK, pick_address(), 8'($urandom), 8'($urandom), rare_cart(),
            $urandom_range(9) != 0, 8'($urandom));
    endtask

    // Load both pads, pulse strobe, then shift bits out
    task automatic joypad_round();
        int n;
        put(CMD_BUTTONS, 16'($urandom), 8'($urandom), 8'($urandom), rare_cart(),
            1'($urandom_range(1)), 8'($urandom));
        put(CMD_BUTTONS, 16'($urandom), 8'($urandom), 8'($urandom), rare_cart(),
            1'($urandom_range(1)), 8'($urandom));
        put(CMD_WRITE, ADDR_JOY1, 8'($urandom | 1), 8'($urandom), 1'b0,
            1'($urandom_range(1)), 8'($urandom));
        if ($urandom_range(1))
            put(CMD_READ, 16'($urandom_range(ADDR_JOY1, ADDR_JOY2)), 8'($urandom),
                8'($urandom), rare_cart(), 1'($urandom_range(1)), 8'($urandom));
        put(CMD_WRITE, ADDR_JOY1, 8'($urandom) & 8'hFE, 8'($urandom), 1'b0,
            1'($urandom_range(1)), 8'($urandom));
        n = $urandom_range(6, 12);
        repeat (n)
            put(CMD_READ, 16'($urandom_range(ADDR_JOY1, ADDR_JOY2)), 8'($urandom),
                8'($urandom), rare_cart(), 1'($urandom_range(1)), 8'($urandom));
    endtask

    // Write work RAM, then read it back through a random mirror
    task automatic ram_round();
        logic [15:0] a;
        logic [15:0] mirror;
        a      = 16'(($urandom_range(3) << 11) | $urandom_range(16'h07FF));
        mirror = 16'($urandom_range(3) << 11) | (a & 16'h07FF);
        put(CMD_WRITE, a, 8'($urandom), 8'($urandom), 1'b0, 1'($urandom_range(1)),
            8'($urandom));
        if ($urandom_range(2) == 0) noise_beat();
        put(CMD_READ, mirror, 8'($urandom), 8'($urandom), 1'($urandom_range(1)),
            1'($urandom_range(1)), 8'($urandom));
    endtask

    // Arm a transfer and run ticks through part of it, with stray beats and rearms
    task automatic dma_round();
        int          n;
        int unsigned r;
        put(CMD_WRITE, ADDR_OAM_DMA, pick_page(), 8'($urandom), 1'b0, 1'($urandom_range(1)),
            8'($urandom));
        n = $urandom_range(12, 60);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 3)
                put(CMD_WRITE, ADDR_OAM_DMA, pick_page(), 8'($urandom), 1'b0,
                    1'($urandom_range(1)), 8'($urandom));
            else if (r < 15)
                noise_beat();
            else
                tick_beat();
        end
    endtask

    task automatic random_part(int count);
        int          start;
        int unsigned r;
        start = beats_sent;
        while (beats_sent - start < count) begin
            r = $urandom_range(99);
            if (r < 25)      joypad_round();
            else if (r < 45) ram_round();
            else if (r < 70) dma_round();
            else if (r < 80) repeat ($urandom_range(1, 8)) tick_beat();
            else             repeat ($urandom_range(1, 4)) noise_beat();
        end
    endtask

    // Walk the address map, the joypad ports and the start of a transfer
    task automatic directed_beats();
        put(CMD_WRITE,   16'h0000, 8'hA5, 8'h00, 1'b0, 1'b0, 8'h00);
        put(CMD_READ,    16'h0800, 8'h00, 8'hFF, 1'b0, 1'b0, 8'h00);
        put(CMD_WRITE,   16'h1FFF, 8'h5A, 8'h00, 1'b0, 1'b0, 8'h00);
        put(CMD_READ,    16'h07FF, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00);
        put(CMD_READ,    16'h2000, 8'h00, 8'h3C, 1'b0, 1'b0, 8'h00);
        put(CMD_WRITE,   16'h3FFF, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00);
        // cartridge takes the write even inside work RAM
        put(CMD_WRITE,   16'h0010, 8'h77, 8'h00, 1'b1, 1'b0, 8'h00);
        put(CMD_READ,    16'hFFFF, 8'h00, 8'hC3, 1'b1, 1'b0, 8'h00);
        // nobody decodes these
        put(CMD_READ,    16'h4018, 8'h00, 8'hEE, 1'b0, 1'b0, 8'h00);
        put(CMD_WRITE,   16'h5000, 8'h11, 8'h00, 1'b0, 1'b0, 8'h00);
        put(CMD_BUTTONS, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'hFF);
        put(CMD_BUTTONS, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'h02);
        put(CMD_WRITE,   ADDR_JOY1, 8'h01, 8'h00, 1'b0, 1'b0, 8'h00);
        // strobe high: no shift
        put(CMD_READ,    ADDR_JOY1, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        put(CMD_WRITE,   ADDR_JOY1, 8'hFE, 8'h00, 1'b0, 1'b0, 8'h00);
        put(CMD_READ,    ADDR_JOY2, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        put(CMD_READ,    ADDR_JOY2, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        put(CMD_WRITE,   ADDR_OAM_DMA, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        put(CMD_TICK,    16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        repeat (6) put(CMD_TICK, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00);
    endtask

    // Sequence the phases
    initial begin
        sb         = new();
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        beats_sent = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_muted(1'b0);
        directed_beats();

        // audio ports with routing muted
        set_muted(1'b1);
        put(CMD_WRITE, ADDR_APU_FIRST,  8'h81, 8'h00, 1'b0, 1'b0, 8'h00);
        put(CMD_WRITE, ADDR_APU_LAST,   8'h42, 8'h00, 1'b0, 1'b0, 8'h00);
        put(CMD_WRITE, ADDR_APU_STATUS, 8'h0F, 8'h00, 1'b0, 1'b0, 8'h00);
        put(CMD_READ,  ADDR_APU_STATUS, 8'h00, 8'h99, 1'b0, 1'b0, 8'h00);

        set_muted(1'b0);
        random_part(200);
        no_idle = 1'b1;
        random_part(150);
        // stall the result side while beats keep coming
        hold_req = 1'b1;
        random_part(40);
        no_idle = 1'b0;

        set_muted(1'b1);
        random_part(250);

        set_muted(1'b0);
        random_part(250);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
